// ===== rtl/complex_arith_unit_core_assert.svh =====
// assertion macros for the complex arithmetic unit
// used by complex_arith_unit_core; needs clk and rst_n in the including scope
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication after a fixed number of cycles
`define CAU_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_DZ   = 2'd2;
    localparam logic [1:0] STAT_RSVD = 2'd3;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic sat;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } ctl_t;

endpackage

// ===== rtl/complex_arith_unit_core.sv =====
// complex arithmetic unit: add, subtract, multiply, divide on signed fixed point
// depends on cau_pkg and complex_arith_unit_core_assert.svh
//
// usage:
//   a request is taken at a rising edge with start high and busy low; busy
//   stays low, so one request may be issued in every cycle
//   req_type selects add, subtract, multiply or divide on (a_re, a_im) and
//   (b_re, b_im); results saturate and status reports ok, saturated or
//   divide by zero
//   done is high for exactly one cycle with res_re, res_im and status valid
//   every operation passes the request register, the product stage, the sum
//   stage, the divider array and the output register; throughput one request
//   per cycle; the depth comes from the divider, a restoring array with one
//   quotient bit per stage; other operations ride along through the same stages
//   reset clears all valid bits, so no done appears from requests in flight
//   the receiver cannot stall: results are presented once and not held
`include "complex_arith_unit_core_assert.svh"

module complex_arith_unit_core #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic [1:0]                   status
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 1;
    localparam int RW  = 3 * W + F + 1;
    localparam int LAT = W + 5;

    localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0]         WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] clamp_w(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > SMAX)
        begin
            r = {1'b1, WMAX};
        end
        else if (v < SMIN)
        begin
            r = {1'b1, WMIN};
        end
        else
        begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // request register
    cau_pkg::ctl_t        s0_ctl_reg, s0_ctl_next;
    logic signed [W-1:0]  s0_ar_reg, s0_ai_reg, s0_br_reg, s0_bi_reg;

    always_comb
    begin
        s0_ctl_next       = '0;
        s0_ctl_next.valid = start & ~busy;
        s0_ctl_next.op    = cau_pkg::op_t'(req_type);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else
        begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_ar_reg <= a_re;
            s0_ai_reg <= a_im;
            s0_br_reg <= b_re;
            s0_bi_reg <= b_im;
        end
    end

    // products and component sums
    cau_pkg::ctl_t         s1_ctl_reg;
    logic signed [PW-1:0]  s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg, s1_bb_reg, s1_cc_reg;
    logic signed [W:0]     s1_sre_reg, s1_sim_reg;
    logic signed [W:0]     s1_sre_next, s1_sim_next;

    always_comb
    begin
        if (s0_ctl_reg.op == cau_pkg::OP_SUB)
        begin
            s1_sre_next = (W+1)'(s0_ar_reg) - (W+1)'(s0_br_reg);
            s1_sim_next = (W+1)'(s0_ai_reg) - (W+1)'(s0_bi_reg);
        end
        else
        begin
            s1_sre_next = (W+1)'(s0_ar_reg) + (W+1)'(s0_br_reg);
            s1_sim_next = (W+1)'(s0_ai_reg) + (W+1)'(s0_bi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s0_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rr_reg  <= PW'(s0_ar_reg) * PW'(s0_br_reg);
        s1_ii_reg  <= PW'(s0_ai_reg) * PW'(s0_bi_reg);
        s1_ri_reg  <= PW'(s0_ar_reg) * PW'(s0_bi_reg);
        s1_ir_reg  <= PW'(s0_ai_reg) * PW'(s0_br_reg);
        s1_bb_reg  <= PW'(s0_br_reg) * PW'(s0_br_reg);
        s1_cc_reg  <= PW'(s0_bi_reg) * PW'(s0_bi_reg);
        s1_sre_reg <= s1_sre_next;
        s1_sim_reg <= s1_sim_next;
    end

    // sums of products, saturation for add/sub/mul, divider operands
    cau_pkg::ctl_t       s2_ctl_reg, s2_ctl_next;
    logic [W-1:0]        s2_re_reg, s2_im_reg, s2_re_next, s2_im_next;
    logic [RW-1:0]       s2_dre_reg, s2_dim_reg, s2_dre_next, s2_dim_next;
    logic [PW-1:0]       s2_den_reg, s2_den_next;
    logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir, mul_re, mul_im, num_re, num_im, den_w;
    logic [SW-1:0]       mag_re, mag_im;
    logic [W:0]          cl_re, cl_im;

    always_comb
    begin
        e_rr   = SW'(s1_rr_reg);
        e_ii   = SW'(s1_ii_reg);
        e_ri   = SW'(s1_ri_reg);
        e_ir   = SW'(s1_ir_reg);
        mul_re = (e_rr - e_ii) >>> F;
        mul_im = (e_ri + e_ir) >>> F;
        num_re = e_rr + e_ii;
        num_im = e_ir - e_ri;
        den_w  = SW'(s1_bb_reg) + SW'(s1_cc_reg);
        mag_re = num_re[SW-1] ? SW'(-num_re) : SW'(num_re);
        mag_im = num_im[SW-1] ? SW'(-num_im) : SW'(num_im);
        s2_den_next = den_w[PW-1:0];
        s2_dre_next = RW'(mag_re) << F;
        s2_dim_next = RW'(mag_im) << F;
        if (s1_ctl_reg.op == cau_pkg::OP_MUL)
        begin
            cl_re = clamp_w(mul_re);
            cl_im = clamp_w(mul_im);
        end
        else
        begin
            cl_re = clamp_w(SW'(s1_sre_reg));
            cl_im = clamp_w(SW'(s1_sim_reg));
        end
        s2_ctl_next        = s1_ctl_reg;
        s2_ctl_next.sat    = cl_re[W] | cl_im[W];
        s2_ctl_next.dz     = (s1_ctl_reg.op == cau_pkg::OP_DIV) && (den_w == '0);
        s2_ctl_next.neg_re = num_re[SW-1];
        s2_ctl_next.neg_im = num_im[SW-1];
        s2_re_next         = cl_re[W-1:0];
        s2_im_next         = cl_im[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_re_reg  <= s2_re_next;
        s2_im_reg  <= s2_im_next;
        s2_dre_reg <= s2_dre_next;
        s2_dim_reg <= s2_dim_next;
        s2_den_reg <= s2_den_next;
    end

    // divider array: entry 0 holds the overflow check, entry s+1 has s+1 quotient bits
    cau_pkg::ctl_t  dv_ctl_reg [0:W];
    logic [RW-1:0]  dv_rre_reg [0:W];
    logic [RW-1:0]  dv_rim_reg [0:W];
    logic [W-1:0]   dv_qre_reg [0:W];
    logic [W-1:0]   dv_qim_reg [0:W];
    logic [W-1:0]   dv_pre_reg [0:W];
    logic [W-1:0]   dv_pim_reg [0:W];
    logic [PW-1:0]  dv_den_reg [0:W];
    cau_pkg::ctl_t  dv0_ctl_next;

    always_comb
    begin
        dv0_ctl_next        = s2_ctl_reg;
        dv0_ctl_next.ovf_re = s2_dre_reg >= (RW'(s2_den_reg) << W);
        dv0_ctl_next.ovf_im = s2_dim_reg >= (RW'(s2_den_reg) << W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_ctl_reg[0] <= '0;
        end
        else
        begin
            dv_ctl_reg[0] <= dv0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rre_reg[0] <= s2_dre_reg;
        dv_rim_reg[0] <= s2_dim_reg;
        dv_qre_reg[0] <= '0;
        dv_qim_reg[0] <= '0;
        dv_pre_reg[0] <= s2_re_reg;
        dv_pim_reg[0] <= s2_im_reg;
        dv_den_reg[0] <= s2_den_reg;
    end

    for (genvar s = 0; s < W; s++)
    begin : g_div
        localparam int K = W - 1 - s;
        logic [RW-1:0] trial;
        logic [RW-1:0] rre_next, rim_next;
        logic [W-1:0]  qre_next, qim_next;

        always_comb
        begin
            trial    = RW'(dv_den_reg[s]) << K;
            rre_next = dv_rre_reg[s];
            rim_next = dv_rim_reg[s];
            qre_next = dv_qre_reg[s];
            qim_next = dv_qim_reg[s];
            if (dv_rre_reg[s] >= trial)
            begin
                rre_next    = dv_rre_reg[s] - trial;
                qre_next[K] = 1'b1;
            end
            if (dv_rim_reg[s] >= trial)
            begin
                rim_next    = dv_rim_reg[s] - trial;
                qim_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl_reg[s+1] <= '0;
            end
            else
            begin
                dv_ctl_reg[s+1] <= dv_ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rre_reg[s+1] <= rre_next;
            dv_rim_reg[s+1] <= rim_next;
            dv_qre_reg[s+1] <= qre_next;
            dv_qim_reg[s+1] <= qim_next;
            dv_pre_reg[s+1] <= dv_pre_reg[s];
            dv_pim_reg[s+1] <= dv_pim_reg[s];
            dv_den_reg[s+1] <= dv_den_reg[s];
        end
    end

    // quotient saturation and result select
    cau_pkg::ctl_t  fc;
    logic [W-1:0]   qr, qi, dre, dim;
    logic           sre, sim;
    logic           done_reg;
    logic [W-1:0]   res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [1:0]     status_reg, status_next;

    always_comb
    begin
        fc = dv_ctl_reg[W];
        qr = dv_qre_reg[W];
        qi = dv_qim_reg[W];
        if (fc.neg_re)
        begin
            sre = fc.ovf_re | (qr[W-1] & (|qr[W-2:0]));
            dre = sre ? WMIN : W'(-qr);
        end
        else
        begin
            sre = fc.ovf_re | qr[W-1];
            dre = sre ? WMAX : qr;
        end
        if (fc.neg_im)
        begin
            sim = fc.ovf_im | (qi[W-1] & (|qi[W-2:0]));
            dim = sim ? WMIN : W'(-qi);
        end
        else
        begin
            sim = fc.ovf_im | qi[W-1];
            dim = sim ? WMAX : qi;
        end
        if (fc.op != cau_pkg::OP_DIV)
        begin
            res_re_next = dv_pre_reg[W];
            res_im_next = dv_pim_reg[W];
            status_next = fc.sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
        else if (fc.dz)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = cau_pkg::STAT_DZ;
        end
        else
        begin
            res_re_next = dre;
            res_im_next = dim;
            status_next = (sre | sim) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign status = status_reg;

    `CAU_ASSERT_DELAY(a_req_to_done, start && !busy, LAT, done)
    `CAU_ASSERT_IMPL(a_done_from_req, done, $past(start && !busy, LAT))
    `CAU_ASSERT_IMPL(a_status_code, done, status != cau_pkg::STAT_RSVD)
    `CAU_ASSERT_IMPL(a_dz_zero, done && status == cau_pkg::STAT_DZ, res_re == '0 && res_im == '0)

endmodule
